@@ hdl/rlf_pkg.sv @@
`timescale 1ns / 1ps

package rlf_pkg;

  // fixed field widths
  localparam int SAMPLE_W   = 6;
  localparam int ITER_W     = 10;
  localparam int TOL_W      = 15;
  localparam int MASK_W     = 64;
  localparam int TOTAL_W    = 7;
  localparam int OUT_DW     = ((MASK_W + TOTAL_W + 7) / 8) * 8;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 15;

  localparam logic [CFG_IDX_W-1:0] CFG_ITER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL  = 1'b1;

  localparam logic [ITER_W-1:0] ITER_RST = 10'd50;
  localparam logic [TOL_W-1:0]  TOL_RST  = 15'd26;

  // fit sequencer states
  typedef enum logic [4:0] {
    ST_LOAD,
    ST_START,
    ST_SAMP_RD,
    ST_SAMP_WAIT,
    ST_SAMP_MOD,
    ST_PA_RD,
    ST_PB_RD,
    ST_PB_WAIT,
    ST_LEN_X,
    ST_LEN_Y,
    ST_LEN_SUM,
    ST_HMUL,
    ST_HACC,
    ST_SQRT,
    ST_PT_RD,
    ST_PT_WAIT,
    ST_PT_M1,
    ST_PT_M2,
    ST_PT_CMP,
    ST_HYP_END,
    ST_DONE
  } fit_state_t;

endpackage

@@ hdl/rlf_ram.sv @@
`timescale 1ns / 1ps

module rlf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/ransac_line_fit_2d.sv @@
`timescale 1ns / 1ps

// channel  dir  handshake           payload
// in_      in   tvalid/tready       tdata: point_x, point_y, sample_entry; tlast: last_point
// out_     out  tvalid/tready       tdata: inlier_mask, inlier_total
// cfg_     in   we (no wait)        index 0 iteration_count, 1 distance_tolerance
//
// a point word is taken on each in_ handshake; a word with tlast starts the fit
// the fit shares a single multiplier and uses a bit-per-cycle square root
// in_tready is high only while loading; a result waiting on out_ does not block loading
// rst_n is synchronous, active low; the point memory needs no clearing pass

module ransac_line_fit_2d #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // point_x, point_y, sample_entry, zero pad
  input  logic [((2*COORD_BITS+rlf_pkg::SAMPLE_W+7)/8)*8-1:0] in_tdata,
  input  logic in_tlast,
  output logic out_tvalid,
  input  logic out_tready,
  // inlier_mask, inlier_total, zero pad
  output logic [rlf_pkg::OUT_DW-1:0] out_tdata,
  input  logic cfg_we,
  input  logic [rlf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rlf_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CB       = COORD_BITS;
  localparam int AW       = $clog2(MAX_POINTS);
  localparam int CNT_W    = $clog2(MAX_POINTS + 1);
  localparam int MOD_W    = CNT_W + 1;
  localparam int MEM_W    = 2 * CB + rlf_pkg::SAMPLE_W;
  localparam int D_W      = CB + 1;
  localparam int OW       = (D_W > rlf_pkg::TOL_W + 1) ? D_W : rlf_pkg::TOL_W + 1;
  localparam int CW       = OW - 1;
  localparam int PW       = 2 * OW;
  localparam int LEN_W    = 2 * CB + 1;
  localparam int R1_W     = LEN_W + rlf_pkg::TOL_W;
  localparam int N1       = (LEN_W + CW - 1) / CW;
  localparam int N2       = (R1_W + CW - 1) / CW;
  localparam int SH_W     = N2 * CW;
  localparam int RWE      = 2 * CB + 32;
  localparam int ACC_W    = (RWE > SH_W) ? RWE : SH_W;
  localparam int RT_W     = RWE / 2;
  localparam int SQR_W    = RT_W + 2;
  localparam int THR_W    = RT_W + 1;
  localparam int CMP_W    = (PW > THR_W) ? PW : THR_W;
  localparam int STEP_W   = $clog2(RT_W);

  localparam int ITER_W   = rlf_pkg::ITER_W;
  localparam int TOL_W    = rlf_pkg::TOL_W;
  localparam int MASK_W   = rlf_pkg::MASK_W;
  localparam int TOTAL_W  = rlf_pkg::TOTAL_W;
  localparam int SAMPLE_W = rlf_pkg::SAMPLE_W;

  rlf_pkg::fit_state_t state_r, state_nxt;

  logic [ITER_W-1:0]  iter_r;
  logic [TOL_W-1:0]   tol_r;

  logic [CNT_W-1:0]   loaded_r, loaded_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [ITER_W-1:0]  k_r, k_nxt;
  logic [AW-1:0]      p0_r, p0_nxt;
  logic               second_r, second_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic               pass_r, pass_nxt;
  logic [AW-1:0]      i_r, i_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [SAMPLE_W-1:0] mod_sh_r, mod_sh_nxt;
  logic [CNT_W-1:0]    mod_rem_r, mod_rem_nxt;
  logic [AW-1:0]       a_r, a_nxt;
  logic [AW-1:0]       b_r, b_nxt;
  logic signed [CB-1:0]  x0_r, x0_nxt;
  logic signed [CB-1:0]  y0_r, y0_nxt;
  logic signed [D_W-1:0] dx_r, dx_nxt;
  logic signed [D_W-1:0] dy_r, dy_nxt;
  logic signed [D_W-1:0] ex_r, ex_nxt;
  logic signed [D_W-1:0] ey_r, ey_nxt;
  logic signed [PW-1:0]  prod_r;
  logic signed [PW-1:0]  cacc_r, cacc_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [SH_W-1:0]     sh_r, sh_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [RWE-1:0]      sq_sh_r, sq_sh_nxt;
  logic [SQR_W-1:0]    sq_rem_r, sq_rem_nxt;
  logic [RT_W-1:0]     sq_root_r, sq_root_nxt;
  logic [THR_W-1:0]    thr_r, thr_nxt;
  logic [MASK_W-1:0]   trial_mask_r, trial_mask_nxt;
  logic [TOTAL_W-1:0]  trial_total_r, trial_total_nxt;
  logic [MASK_W-1:0]   best_mask_r, best_mask_nxt;
  logic [TOTAL_W-1:0]  best_total_r, best_total_nxt;
  logic [MASK_W-1:0]   out_mask_r, out_mask_nxt;
  logic [TOTAL_W-1:0]  out_total_r, out_total_nxt;

  // point memory: sample entry, y, x in the same layout as the input word
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  logic [MEM_W-1:0]  ram_rdata;
  logic signed [CB-1:0] rd_x, rd_y;
  logic [SAMPLE_W-1:0]  rd_samp;

  rlf_ram #(
    .WIDTH (MEM_W),
    .DEPTH (MAX_POINTS)
  ) u_point_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_tdata[MEM_W-1:0]),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_x    = ram_rdata[CB-1:0];
  assign rd_y    = ram_rdata[2*CB-1:CB];
  assign rd_samp = ram_rdata[2*CB +: SAMPLE_W];

  // shared multiplier
  logic signed [OW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] mul_p;
  assign mul_p = mul_a * mul_b;

  // restoring remainder, one sample bit per cycle
  logic [MOD_W-1:0] mod_try;
  logic [CNT_W-1:0] mod_rem_new;
  assign mod_try     = {mod_rem_r, mod_sh_r[SAMPLE_W-1]};
  assign mod_rem_new = (mod_try >= MOD_W'(n_r)) ? CNT_W'(mod_try - MOD_W'(n_r))
                                                : CNT_W'(mod_try);

  // next sample position, wrapping at the point count
  logic          p0_last;
  logic [AW-1:0] p1;
  assign p0_last = (CNT_W'(p0_r) + CNT_W'(1)) == n_r;
  assign p1      = p0_last ? '0 : p0_r + AW'(1);

  // horner step for the wide threshold product
  logic [ACC_W-1:0] acc_sum;
  logic             chunk_last;
  assign acc_sum    = (acc_r << CW) + ACC_W'($unsigned(prod_r));
  assign chunk_last = step_r == (pass_r ? STEP_W'(N2 - 1) : STEP_W'(N1 - 1));

  // integer square root, one result bit per cycle
  logic [SQR_W-1:0] sq_cat, sq_trial, sq_rem_new;
  logic             sq_ge;
  logic [RT_W-1:0]  sq_root_new;
  assign sq_cat      = {sq_rem_r[SQR_W-3:0], sq_sh_r[RWE-1 -: 2]};
  assign sq_trial    = {sq_root_r, 2'b01};
  assign sq_ge       = sq_cat >= sq_trial;
  assign sq_rem_new  = sq_ge ? sq_cat - sq_trial : sq_cat;
  assign sq_root_new = {sq_root_r[RT_W-2:0], sq_ge};

  // distance test against the rounded-up root of tol^2 * len^2
  logic signed [PW-1:0] cross_v;
  logic [PW-1:0]        cmag;
  logic                 hit;
  logic                 i_last;
  assign cross_v = cacc_r - prod_r;
  assign cmag    = cross_v[PW-1] ? $unsigned(-cross_v) : $unsigned(cross_v);
  assign hit     = CMP_W'(cmag) < CMP_W'(thr_r);
  assign i_last  = (CNT_W'(i_r) + CNT_W'(1)) == n_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iter_r <= rlf_pkg::ITER_RST;
      tol_r  <= rlf_pkg::TOL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rlf_pkg::CFG_ITER: iter_r <= cfg_wdata[ITER_W-1:0];
        rlf_pkg::CFG_TOL:  tol_r  <= cfg_wdata[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rlf_pkg::ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      loaded_r    <= loaded_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    n_r           <= n_nxt;
    k_r           <= k_nxt;
    p0_r          <= p0_nxt;
    second_r      <= second_nxt;
    step_r        <= step_nxt;
    pass_r        <= pass_nxt;
    i_r           <= i_nxt;
    mod_sh_r      <= mod_sh_nxt;
    mod_rem_r     <= mod_rem_nxt;
    a_r           <= a_nxt;
    b_r           <= b_nxt;
    x0_r          <= x0_nxt;
    y0_r          <= y0_nxt;
    dx_r          <= dx_nxt;
    dy_r          <= dy_nxt;
    ex_r          <= ex_nxt;
    ey_r          <= ey_nxt;
    prod_r        <= mul_p;
    cacc_r        <= cacc_nxt;
    len_r         <= len_nxt;
    sh_r          <= sh_nxt;
    acc_r         <= acc_nxt;
    sq_sh_r       <= sq_sh_nxt;
    sq_rem_r      <= sq_rem_nxt;
    sq_root_r     <= sq_root_nxt;
    thr_r         <= thr_nxt;
    trial_mask_r  <= trial_mask_nxt;
    trial_total_r <= trial_total_nxt;
    best_mask_r   <= best_mask_nxt;
    best_total_r  <= best_total_nxt;
    out_mask_r    <= out_mask_nxt;
    out_total_r   <= out_total_nxt;
  end

  // sequencer: next state and datapath control
  always_comb begin
    state_nxt       = state_r;
    loaded_nxt      = loaded_r;
    n_nxt           = n_r;
    k_nxt           = k_r;
    p0_nxt          = p0_r;
    second_nxt      = second_r;
    step_nxt        = step_r;
    pass_nxt        = pass_r;
    i_nxt           = i_r;
    mod_sh_nxt      = mod_sh_r;
    mod_rem_nxt     = mod_rem_r;
    a_nxt           = a_r;
    b_nxt           = b_r;
    x0_nxt          = x0_r;
    y0_nxt          = y0_r;
    dx_nxt          = dx_r;
    dy_nxt          = dy_r;
    ex_nxt          = ex_r;
    ey_nxt          = ey_r;
    cacc_nxt        = cacc_r;
    len_nxt         = len_r;
    sh_nxt          = sh_r;
    acc_nxt         = acc_r;
    sq_sh_nxt       = sq_sh_r;
    sq_rem_nxt      = sq_rem_r;
    sq_root_nxt     = sq_root_r;
    thr_nxt         = thr_r;
    trial_mask_nxt  = trial_mask_r;
    trial_total_nxt = trial_total_r;
    best_mask_nxt   = best_mask_r;
    best_total_nxt  = best_total_r;
    out_mask_nxt    = out_mask_r;
    out_total_nxt   = out_total_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    in_tready       = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = AW'(loaded_r);
    ram_raddr       = i_r;
    mul_a           = dx_r;
    mul_b           = dx_r;

    unique case (state_r)
      rlf_pkg::ST_LOAD: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (loaded_r < CNT_W'(MAX_POINTS)) begin
            ram_we     = 1'b1;
            loaded_nxt = loaded_r + CNT_W'(1);
          end
          if (in_tlast) begin
            n_nxt     = loaded_nxt;
            state_nxt = rlf_pkg::ST_START;
          end
        end
      end

      rlf_pkg::ST_START: begin
        best_mask_nxt  = '0;
        best_total_nxt = '0;
        k_nxt          = '0;
        p0_nxt         = '0;
        second_nxt     = 1'b0;
        state_nxt      = (iter_r == '0) ? rlf_pkg::ST_DONE : rlf_pkg::ST_SAMP_RD;
      end

      // fetch the sampling-order entry and reduce it modulo the count
      rlf_pkg::ST_SAMP_RD: begin
        ram_raddr = second_r ? p1 : p0_r;
        state_nxt = rlf_pkg::ST_SAMP_WAIT;
      end

      rlf_pkg::ST_SAMP_WAIT: begin
        mod_sh_nxt  = rd_samp;
        mod_rem_nxt = '0;
        step_nxt    = '0;
        state_nxt   = rlf_pkg::ST_SAMP_MOD;
      end

      rlf_pkg::ST_SAMP_MOD: begin
        mod_rem_nxt = mod_rem_new;
        mod_sh_nxt  = mod_sh_r << 1;
        step_nxt    = step_r + STEP_W'(1);
        if (step_r == STEP_W'(SAMPLE_W - 1)) begin
          if (!second_r) begin
            a_nxt      = AW'(mod_rem_new);
            second_nxt = 1'b1;
            state_nxt  = rlf_pkg::ST_SAMP_RD;
          end else begin
            b_nxt     = AW'(mod_rem_new);
            state_nxt = rlf_pkg::ST_PA_RD;
          end
        end
      end

      // line endpoints and direction
      rlf_pkg::ST_PA_RD: begin
        ram_raddr = a_r;
        state_nxt = rlf_pkg::ST_PB_RD;
      end

      rlf_pkg::ST_PB_RD: begin
        ram_raddr = b_r;
        x0_nxt    = rd_x;
        y0_nxt    = rd_y;
        state_nxt = rlf_pkg::ST_PB_WAIT;
      end

      rlf_pkg::ST_PB_WAIT: begin
        dx_nxt    = D_W'(rd_x) - D_W'(x0_r);
        dy_nxt    = D_W'(rd_y) - D_W'(y0_r);
        state_nxt = rlf_pkg::ST_LEN_X;
      end

      // squared direction length
      rlf_pkg::ST_LEN_X: begin
        mul_a     = dx_r;
        mul_b     = dx_r;
        state_nxt = rlf_pkg::ST_LEN_Y;
      end

      rlf_pkg::ST_LEN_Y: begin
        mul_a     = dy_r;
        mul_b     = dy_r;
        len_nxt   = LEN_W'($unsigned(prod_r));
        state_nxt = rlf_pkg::ST_LEN_SUM;
      end

      rlf_pkg::ST_LEN_SUM: begin
        sh_nxt    = SH_W'(len_r + LEN_W'($unsigned(prod_r))) << (SH_W - N1 * CW);
        acc_nxt   = '0;
        pass_nxt  = 1'b0;
        step_nxt  = '0;
        state_nxt = rlf_pkg::ST_HMUL;
      end

      // tol * tol * len2, one chunk per multiply, high chunk first
      rlf_pkg::ST_HMUL: begin
        mul_a     = OW'(tol_r);
        mul_b     = OW'(sh_r[SH_W-1 -: CW]);
        sh_nxt    = sh_r << CW;
        state_nxt = rlf_pkg::ST_HACC;
      end

      rlf_pkg::ST_HACC: begin
        acc_nxt   = acc_sum;
        step_nxt  = step_r + STEP_W'(1);
        state_nxt = rlf_pkg::ST_HMUL;
        if (chunk_last) begin
          step_nxt = '0;
          if (!pass_r) begin
            sh_nxt   = SH_W'(acc_sum);
            acc_nxt  = '0;
            pass_nxt = 1'b1;
          end else begin
            sq_sh_nxt   = RWE'(acc_sum);
            sq_rem_nxt  = '0;
            sq_root_nxt = '0;
            state_nxt   = rlf_pkg::ST_SQRT;
          end
        end
      end

      rlf_pkg::ST_SQRT: begin
        sq_sh_nxt   = sq_sh_r << 2;
        sq_rem_nxt  = sq_rem_new;
        sq_root_nxt = sq_root_new;
        step_nxt    = step_r + STEP_W'(1);
        if (step_r == STEP_W'(RT_W - 1)) begin
          thr_nxt         = THR_W'(sq_root_new) + THR_W'(sq_rem_new != '0);
          i_nxt           = '0;
          trial_mask_nxt  = '0;
          trial_total_nxt = '0;
          state_nxt       = rlf_pkg::ST_PT_RD;
        end
      end

      // per-point distance test
      rlf_pkg::ST_PT_RD: begin
        ram_raddr = i_r;
        state_nxt = rlf_pkg::ST_PT_WAIT;
      end

      rlf_pkg::ST_PT_WAIT: begin
        ex_nxt    = D_W'(rd_x) - D_W'(x0_r);
        ey_nxt    = D_W'(rd_y) - D_W'(y0_r);
        state_nxt = rlf_pkg::ST_PT_M1;
      end

      rlf_pkg::ST_PT_M1: begin
        mul_a     = dx_r;
        mul_b     = ey_r;
        state_nxt = rlf_pkg::ST_PT_M2;
      end

      rlf_pkg::ST_PT_M2: begin
        mul_a     = dy_r;
        mul_b     = ex_r;
        cacc_nxt  = prod_r;
        state_nxt = rlf_pkg::ST_PT_CMP;
      end

      rlf_pkg::ST_PT_CMP: begin
        if (hit) begin
          trial_mask_nxt  = trial_mask_r | (MASK_W'(1) << i_r);
          trial_total_nxt = trial_total_r + TOTAL_W'(1);
        end
        i_nxt     = i_r + AW'(1);
        state_nxt = i_last ? rlf_pkg::ST_HYP_END : rlf_pkg::ST_PT_RD;
      end

      // keep the first hypothesis with the most inliers
      rlf_pkg::ST_HYP_END: begin
        if (trial_total_r > best_total_r) begin
          best_mask_nxt  = trial_mask_r;
          best_total_nxt = trial_total_r;
        end
        if (k_r + ITER_W'(1) == iter_r) begin
          state_nxt = rlf_pkg::ST_DONE;
        end else begin
          k_nxt      = k_r + ITER_W'(1);
          p0_nxt     = p1;
          second_nxt = 1'b0;
          state_nxt  = rlf_pkg::ST_SAMP_RD;
        end
      end

      // hand the result to the output register once it is free
      rlf_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_mask_nxt  = best_mask_r;
          out_total_nxt = best_total_r;
          out_valid_nxt = 1'b1;
          loaded_nxt    = '0;
          state_nxt     = rlf_pkg::ST_LOAD;
        end
      end

      default: begin
        state_nxt = rlf_pkg::ST_LOAD;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(rlf_pkg::OUT_DW - MASK_W - TOTAL_W){1'b0}}, out_total_r, out_mask_r};

  // checks
  a_idx_in_set: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rlf_pkg::ST_PT_CMP) |-> (CNT_W'(i_r) < n_r))
    else $error("point index past loaded count");

  a_ends_in_set: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rlf_pkg::ST_PA_RD) |-> (CNT_W'(a_r) < n_r && CNT_W'(b_r) < n_r))
    else $error("line endpoint outside loaded set");

  a_mask_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($countones(out_mask_r) == int'(out_total_r)))
    else $error("inlier total disagrees with mask");

  a_done_hand: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rlf_pkg::ST_DONE && (!out_valid_r || out_tready))
      |=> (state_r == rlf_pkg::ST_LOAD && loaded_r == '0 && out_valid_r))
    else $error("result not handed over after fit");

endmodule
